// File: src/sha_pkg.sv
// Shared types, constants and round functions of the SHA-256 engine.
`default_nettype none
package sha_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned WORDS     = 8;
	localparam int unsigned ROUNDS    = 64;
	localparam int unsigned WIN_WORDS = 16;
	localparam int unsigned WIN_W     = WORD_W * WIN_WORDS;

	localparam logic [5:0] FILL_LAST  = 6'd63;
	localparam logic [5:0] LEN_OFFSET = 6'd56;
	localparam logic [5:0] ROUND_LAST = 6'd63;
	localparam logic [3:0] LEN_BYTES  = 4'd8;
	localparam logic [2:0] WORD_LAST  = 3'd7;
	localparam logic [7:0] PAD_MARKER = 8'h80;

	localparam logic [31:0] SHA_IV [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] SHA_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_FINAL,
		ST_PAD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       push;
		logic [7:0] push_byte;
		logic       load_work;
		logic       round_en;
		logic       add_chain;
		logic       init_chain;
		logic [5:0] rnd;
		logic [2:0] word_idx;
	} ctl_t;

	function automatic logic [31:0] rot_mix_a(input logic [31:0] x);
		rot_mix_a = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] rot_mix_e(input logic [31:0] x);
		rot_mix_e = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] sched_mix_w15(input logic [31:0] x);
		sched_mix_w15 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] sched_mix_w2(input logic [31:0] x);
		sched_mix_w2 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage
`default_nettype wire

// File: src/sha_if.sv
// Valid/ready channel interfaces for message bytes and digest words.
`default_nettype none
interface sha_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       message_end;

	modport source (output valid, data_byte, byte_present, message_end, input ready);
	modport sink (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sha_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_number;
	logic        digest_last;

	modport source (output valid, digest_word, word_number, digest_last, input ready);
	modport sink (input valid, digest_word, word_number, digest_last, output ready);
endinterface
`default_nettype wire

// File: src/sha256_hash_engine.sv
// SHA-256 hash engine top level: byte intake channel in, digest word channel out.
//
// msg channel: one word per handshake carries data_byte, byte_present and
// message_end. A word with byte_present appends data_byte to the message; a
// word with message_end closes the message (after its byte, if any). A word
// with neither flag is accepted and does nothing.
// digest channel: eight words per message, word_number 0 to 7, digest_last on
// the final one; each holds one big-endian 32-bit digest word.
// Timing: a byte that does not fill the block leaves the engine idle. The 64th
// byte of a block starts the shared round unit: 64 rounds at one per cycle,
// then a final step folds the result into the chaining words; no new byte is
// taken until that is done. An end word pushes padding one byte per cycle
// (9 to 72 bytes) through the same path, with one or two compressions, then
// presents the digest.
// msg.ready is high only while the engine is idle; it stays low through
// compression, padding and digest output.
// A stalled receiver holds the current digest word on the channel; the engine
// waits and takes no new message words until all eight words are taken.
// Reset clears the sequencer, the fill and byte counts, and loads the initial
// chaining words; the block buffer needs no clearing.
`default_nettype none
module sha256_hash_engine (
	input  wire logic clk,
	input  wire logic arst_n,
	sha_msg_if.sink       msg,
	sha_digest_if.source  digest
);
	import sha_pkg::*;

	ctl_t        ctl;
	logic [31:0] w_cur;
	logic [31:0] chain_word;

	// Sequencer: owns both handshakes and steps the datapath.
	sha_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (msg.valid),
		.data_byte    (msg.data_byte),
		.byte_present (msg.byte_present),
		.message_end  (msg.message_end),
		.out_ready    (digest.ready),
		.in_ready     (msg.ready),
		.out_valid    (digest.valid),
		.ctl          (ctl)
	);

	// Block bytes shift in here and become the message schedule in place.
	sha_sched u_sched (
		.clk   (clk),
		.ctl   (ctl),
		.w_cur (w_cur)
	);

	// One round per cycle while compressing; chaining words double as the digest output register.
	sha_round u_round (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.w_cur       (w_cur),
		.digest_word (chain_word)
	);

	assign digest.digest_word = chain_word;
	assign digest.word_number = ctl.word_idx;
	assign digest.digest_last = (ctl.word_idx == WORD_LAST);
endmodule
`default_nettype wire

// File: src/sha_sched.sv
// Block buffer and message schedule window, one shift register for both.
`default_nettype none
module sha_sched (
	input  wire logic          clk,
	input  wire sha_pkg::ctl_t ctl,
	output logic [31:0]        w_cur
);
	import sha_pkg::*;

	logic [WIN_W-1:0] win_q;
	logic [31:0]      w_new;

	// Oldest word sits at the top; taps at t-16, t-15, t-7 and t-2.
	assign w_cur = win_q[WIN_W-1 -: WORD_W];
	assign w_new = sched_mix_w2(win_q[63:32]) + win_q[223:192]
		+ sched_mix_w15(win_q[479:448]) + w_cur;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			win_q <= {win_q[WIN_W-9:0], ctl.push_byte};
		end else if (ctl.round_en) begin
			win_q <= {win_q[WIN_W-WORD_W-1:0], w_new};
		end
	end
endmodule
`default_nettype wire

// File: src/sha_round.sv
// Shared round unit: working variables, chaining words and digest word select.
`default_nettype none
module sha_round (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sha_pkg::ctl_t ctl,
	input  wire logic [31:0]   w_cur,
	output logic [31:0]        digest_word
);
	import sha_pkg::*;

	logic [31:0] work_q  [0:7];
	logic [31:0] chain_q [0:7];
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;

	assign ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
	assign t1  = work_q[7] + rot_mix_e(work_q[4]) + ch + SHA_K[ctl.rnd] + w_cur;
	assign t2  = rot_mix_a(work_q[0]) + maj;

	assign digest_word = chain_q[ctl.word_idx];

	always_ff @(posedge clk) begin
		if (ctl.load_work) begin
			for (int i = 0; i < WORDS; i++) begin
				work_q[i] <= chain_q[i];
			end
		end else if (ctl.round_en) begin
			work_q[0] <= t1 + t2;
			work_q[1] <= work_q[0];
			work_q[2] <= work_q[1];
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3] + t1;
			work_q[5] <= work_q[4];
			work_q[6] <= work_q[5];
			work_q[7] <= work_q[6];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORDS; i++) begin
				chain_q[i] <= SHA_IV[i];
			end
		end else if (ctl.init_chain) begin
			for (int i = 0; i < WORDS; i++) begin
				chain_q[i] <= SHA_IV[i];
			end
		end else if (ctl.add_chain) begin
			for (int i = 0; i < WORDS; i++) begin
				chain_q[i] <= chain_q[i] + work_q[i];
			end
		end
	end
endmodule
`default_nettype wire

// File: src/sha_ctrl.sv
// Sequencer: byte intake, padding, round count and digest word output.
`default_nettype none
module sha_ctrl (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] data_byte,
	input  wire logic       byte_present,
	input  wire logic       message_end,
	input  wire logic       out_ready,
	output logic            in_ready,
	output logic            out_valid,
	output sha_pkg::ctl_t   ctl
);
	import sha_pkg::*;

	state_t      state_q, state_d;
	logic [5:0]  fill_q, fill_d;
	logic [63:0] total_q, total_d;
	logic        end_q, end_d;
	logic        marker_q, marker_d;
	logic [3:0]  len_q, len_d;
	logic [5:0]  rnd_q, rnd_d;
	logic [2:0]  idx_q, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			total_q  <= '0;
			end_q    <= 1'b0;
			marker_q <= 1'b0;
			len_q    <= '0;
			rnd_q    <= '0;
			idx_q    <= '0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			total_q  <= total_d;
			end_q    <= end_d;
			marker_q <= marker_d;
			len_q    <= len_d;
			rnd_q    <= rnd_d;
			idx_q    <= idx_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		fill_d         = fill_q;
		total_d        = total_q;
		end_d          = end_q;
		marker_d       = marker_q;
		len_d          = len_q;
		rnd_d          = rnd_q;
		idx_d          = idx_q;
		in_ready       = 1'b0;
		out_valid      = 1'b0;
		ctl            = '0;
		ctl.rnd        = rnd_q;
		ctl.word_idx   = idx_q;

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					marker_d = 1'b0;
					len_d    = '0;
					end_d    = message_end;
					if (byte_present) begin
						ctl.push      = 1'b1;
						ctl.push_byte = data_byte;
						fill_d        = fill_q + 6'd1;
						total_d       = total_q + 64'd1;
						if (fill_q == FILL_LAST) begin
							ctl.load_work = 1'b1;
							state_d       = ST_COMP;
						end else if (message_end) begin
							state_d = ST_PAD;
						end
					end else if (message_end) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_COMP: begin
				ctl.round_en = 1'b1;
				rnd_d        = rnd_q + 6'd1;
				if (rnd_q == ROUND_LAST) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				ctl.add_chain = 1'b1;
				if (len_q == LEN_BYTES) begin
					state_d = ST_EMIT;
				end else if (end_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PAD: begin
				ctl.push = 1'b1;
				fill_d   = fill_q + 6'd1;
				// Marker byte first; the byte count turns into the bit length here.
				if (!marker_q) begin
					ctl.push_byte = PAD_MARKER;
					marker_d      = 1'b1;
					total_d       = {total_q[60:0], 3'b000};
				end else if (len_q == '0 && fill_q != LEN_OFFSET) begin
					ctl.push_byte = 8'h00;
				end else begin
					// Length bytes, most significant first; the count drains to zero.
					ctl.push_byte = total_q[63:56];
					total_d       = {total_q[55:0], 8'h00};
					len_d         = len_q + 4'd1;
				end
				if (fill_q == FILL_LAST) begin
					ctl.load_work = 1'b1;
					state_d       = ST_COMP;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == WORD_LAST) begin
						ctl.init_chain = 1'b1;
						end_d          = 1'b0;
						len_d          = '0;
						state_d        = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire
